[rtl/srtc_pkg.sv]
// shared types, constants and stream-building functions for the serial rtc port
`timescale 1ns / 1ps

package srtc_pkg;

    localparam int STREAM_BITS = 40;

    localparam int STROBE_BIT = 2;
    localparam int CLOCK_BIT  = 1;
    localparam int CMD_LSB    = 3;
    localparam int CMD_WIDTH  = 3;

    localparam logic [CMD_WIDTH-1:0] CMD_SHIFT     = 3'd1;
    localparam logic [CMD_WIDTH-1:0] CMD_TIME_READ = 3'd3;

    localparam logic       ACC_READ    = 1'b0;
    localparam logic       ACC_WRITE   = 1'b1;
    localparam logic [7:0] DATA_SET    = 8'h80;
    localparam logic [7:0] DATA_CLEAR  = 8'h00;

    typedef struct packed {
        logic       command;
        logic [7:0] write_data;
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [4:0] day_of_month;
        logic [2:0] day_of_week;
        logic [3:0] month;
    } item_t;

    // tens digit of a value below 64, by reciprocal multiply
    function automatic logic [3:0] tens_of(input logic [5:0] v);
        logic [13:0] p;
        p = {8'd0, v} * 14'd205;
        return {1'b0, p[13:11]};
    endfunction

    function automatic logic [3:0] ones_of(input logic [5:0] v);
        logic [5:0] t;
        logic [5:0] r;
        t = {2'd0, tens_of(v)};
        r = v - ((t << 3) + (t << 1));
        return r[3:0];
    endfunction

    // ten nibbles: bcd date and time digits, with weekday and month as raw values; lowest nibble shifted out first
    function automatic logic [STREAM_BITS-1:0] build_stream(input item_t it);
        logic [5:0] hr;
        logic [5:0] dom;
        hr  = {1'b0, it.hour};
        dom = {1'b0, it.day_of_month};
        return {it.month,
                {1'b0, it.day_of_week},
                tens_of(dom), ones_of(dom),
                tens_of(hr), ones_of(hr),
                tens_of(it.minute), ones_of(it.minute),
                tens_of(it.second), ones_of(it.second)};
    endfunction

endpackage

[rtl/srtc_if.sv]
// valid/ready channel interfaces for access words and result words
`timescale 1ns / 1ps

interface srtc_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] write_data;
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [4:0] day_of_month;
    logic [2:0] day_of_week;
    logic [3:0] month;

    modport source (
        output valid, command, write_data, second, minute, hour,
               day_of_month, day_of_week, month,
        input  ready
    );
    modport sink (
        input  valid, command, write_data, second, minute, hour,
               day_of_month, day_of_week, month,
        output ready
    );
endinterface

interface srtc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;

    modport source (
        output valid, read_data,
        input  ready
    );
    modport sink (
        input  valid, read_data,
        output ready
    );
endinterface

[rtl/srtc_core.sv]
// chip state: strobe/clock edge detect, command latch and time stream shifter
`timescale 1ns / 1ps

module srtc_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  srtc_pkg::item_t     item,
    output logic [7:0]          read_data
);

    logic                                last_strobe_reg;
    logic                                last_strobe_next;
    logic                                last_clock_reg;
    logic                                last_clock_next;
    logic [srtc_pkg::CMD_WIDTH-1:0]      chip_cmd_reg;
    logic [srtc_pkg::CMD_WIDTH-1:0]      chip_cmd_next;
    logic                                data_bit_reg;
    logic                                data_bit_next;
    logic [srtc_pkg::STREAM_BITS-1:0]    stream_reg;
    logic [srtc_pkg::STREAM_BITS-1:0]    stream_next;

    logic strobe;
    logic clock;

    assign strobe = item.write_data[srtc_pkg::STROBE_BIT];
    assign clock  = item.write_data[srtc_pkg::CLOCK_BIT];

    always_comb
    begin
        last_strobe_next = last_strobe_reg;
        last_clock_next  = last_clock_reg;
        chip_cmd_next    = chip_cmd_reg;
        data_bit_next    = data_bit_reg;
        stream_next      = stream_reg;
        if (fire && item.command == srtc_pkg::ACC_WRITE)
        begin
            if (strobe && !last_strobe_reg)
            begin
                chip_cmd_next = item.write_data[srtc_pkg::CMD_LSB +: srtc_pkg::CMD_WIDTH];
                if (chip_cmd_next == srtc_pkg::CMD_TIME_READ)
                begin
                    stream_next   = srtc_pkg::build_stream(item);
                    data_bit_next = stream_next[0];
                end
            end
            // zero fill makes the bit past the end read as 0
            if (clock && !last_clock_reg &&
                (chip_cmd_next inside {srtc_pkg::CMD_SHIFT, srtc_pkg::CMD_TIME_READ}))
            begin
                stream_next   = {1'b0, stream_next[srtc_pkg::STREAM_BITS-1:1]};
                data_bit_next = stream_next[0];
            end
            last_strobe_next = strobe;
            last_clock_next  = clock;
        end
    end

    assign read_data = data_bit_next ? srtc_pkg::DATA_SET : srtc_pkg::DATA_CLEAR;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_strobe_reg <= 1'b0;
            last_clock_reg  <= 1'b0;
            chip_cmd_reg    <= '0;
            data_bit_reg    <= 1'b0;
            stream_reg      <= '0;
        end
        else
        begin
            last_strobe_reg <= last_strobe_next;
            last_clock_reg  <= last_clock_next;
            chip_cmd_reg    <= chip_cmd_next;
            data_bit_reg    <= data_bit_next;
            stream_reg      <= stream_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(stream_reg) && $stable(data_bit_reg) && $stable(chip_cmd_reg))
        else $error("chip state changed without an access word");

    a_read_holds: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.command == srtc_pkg::ACC_READ
        |=> $stable(stream_reg) && $stable(data_bit_reg) && $stable(last_clock_reg))
        else $error("read access changed chip state");

    a_shift_bit: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.command == srtc_pkg::ACC_WRITE && clock && !last_clock_reg
        && !(strobe && !last_strobe_reg) && chip_cmd_reg == srtc_pkg::CMD_SHIFT
        |=> data_bit_reg == $past(stream_reg[1]))
        else $error("shift did not present the next stream bit");
`endif

endmodule

[rtl/serial_rtc_bit_shift_port_top.sv]
// path: an accepted word is held in the input register; its result is then loaded into the
// result register when that register is empty or its result is being taken
// throughput: one access word per cycle, limited only by the result handshake
// each word is processed by short combinational logic between the two registers
// reset: asynchronous, clears pipeline valids, chip command, edge history and the
// 40-bit time stream to zeros; the first word may be accepted right after reset
`timescale 1ns / 1ps

module serial_rtc_bit_shift_port_top (
    input  logic         clk,
    input  logic         rst_n,
    srtc_in_if.sink      req,
    srtc_out_if.source   rsp
);

    logic              s1_valid_reg;
    logic              s1_valid_next;
    srtc_pkg::item_t   s1_item_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [7:0]        read_data_reg;
    logic [7:0]        core_read_data;

    logic adv;
    logic fire;
    logic take;

    assign adv  = !out_valid_reg || rsp.ready;
    assign fire = s1_valid_reg && adv;
    assign req.ready = !s1_valid_reg || adv;
    assign take = req.valid && req.ready;

    assign s1_valid_next  = take ? 1'b1 : (fire ? 1'b0 : s1_valid_reg);
    assign out_valid_next = fire ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);

    srtc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (s1_item_reg),
        .read_data (core_read_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_item_reg.command      <= req.command;
            s1_item_reg.write_data   <= req.write_data;
            s1_item_reg.second       <= req.second;
            s1_item_reg.minute       <= req.minute;
            s1_item_reg.hour         <= req.hour;
            s1_item_reg.day_of_month <= req.day_of_month;
            s1_item_reg.day_of_week  <= req.day_of_week;
            s1_item_reg.month        <= req.month;
        end
        if (fire)
        begin
            read_data_reg <= core_read_data;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.read_data = read_data_reg;

`ifndef NO_ASSERTIONS
    a_fire_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("processed word did not reach the result register");

    a_data_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> read_data_reg[6:0] == 7'd0)
        else $error("result word has bits other than the data bit");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !adv |=> s1_valid_reg && $stable(s1_item_reg))
        else $error("input register lost a word while stalled");
`endif

endmodule
